FILE: rtl/core/tlva_pkg.sv
// Shared types and constants for the two-lane 64-bit vector ALU.
// No dependencies; used by the interfaces, the lane, the control and the top level.
package tlva_pkg;

	localparam int unsigned DATA_W      = 64;
	localparam int unsigned KIND_W      = 5;
	localparam int unsigned DIV_STAGES  = DATA_W;          // one quotient bit per stage
	localparam int unsigned PIPE_DEPTH  = DIV_STAGES + 2;  // setup + divider + result
	localparam int unsigned HALF_W      = DATA_W / 2;
	localparam int unsigned SHAMT_W     = $clog2(DATA_W);

	typedef enum logic [KIND_W-1:0] {
		OP_NEG  = 5'd0,
		OP_ZT   = 5'd1,
		OP_NOT  = 5'd2,
		OP_ADD  = 5'd3,
		OP_SUB  = 5'd4,
		OP_MUL  = 5'd5,
		OP_DIV  = 5'd6,
		OP_MOD  = 5'd7,
		OP_AND  = 5'd8,
		OP_OR   = 5'd9,
		OP_XOR  = 5'd10,
		OP_SHL  = 5'd11,
		OP_SHR  = 5'd12,
		OP_LT   = 5'd13,
		OP_GT   = 5'd14,
		OP_LE   = 5'd15,
		OP_GE   = 5'd16,
		OP_EQ   = 5'd17
	} op_t;

	// how the result stage finishes a beat
	typedef enum logic [1:0] {
		MODE_SIMPLE = 2'd0,
		MODE_MUL    = 2'd1,
		MODE_DIV    = 2'd2,
		MODE_MOD    = 2'd3
	} mode_t;

	typedef struct packed {
		mode_t              mode;
		logic               zd;     // divisor is zero
		logic               qneg;   // quotient needs negation
		logic               rneg;   // remainder needs negation
		logic [DATA_W-1:0]  res;    // simple result, low product, or dividend
		logic [HALF_W-1:0]  p1;     // cross products, low halves
		logic [HALF_W-1:0]  p2;
	} lane_ctl_t;

endpackage

FILE: rtl/core/tlva_if.sv
// Valid/ready channel interfaces for the vector ALU request and response.
// Depends on tlva_pkg for field widths.
interface tlva_req_if import tlva_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] kind;
	logic              is_not_equal;
	logic signed [DATA_W-1:0] a_x;
	logic signed [DATA_W-1:0] a_y;
	logic signed [DATA_W-1:0] b_x;
	logic signed [DATA_W-1:0] b_y;

	modport source (output valid, kind, is_not_equal, a_x, a_y, b_x, b_y, input ready);
	modport sink   (input valid, kind, is_not_equal, a_x, a_y, b_x, b_y, output ready);
endinterface

interface tlva_rsp_if import tlva_pkg::*; ();
	logic              valid;
	logic              ready;
	logic signed [DATA_W-1:0] r_x;
	logic signed [DATA_W-1:0] r_y;
	logic              zero_divisor_x;
	logic              zero_divisor_y;

	modport source (output valid, r_x, r_y, zero_divisor_x, zero_divisor_y, input ready);
	modport sink   (input valid, r_x, r_y, zero_divisor_x, zero_divisor_y, output ready);
endinterface

FILE: rtl/core/tlva_lane.sv
// One ALU lane: setup stage, 64-stage restoring divider, result stage.
// Depends on tlva_pkg. All stages advance together on en.
module tlva_lane import tlva_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic [KIND_W-1:0]        kind,
	input  logic                     is_not_equal,
	input  logic signed [DATA_W-1:0] a,
	input  logic signed [DATA_W-1:0] b,
	input  logic [DATA_W-1:0]        shl_cnt,
	output logic [DATA_W-1:0]        r,
	output logic                     zero_divisor
);

	lane_ctl_t         ctl_c;
	logic [DATA_W-1:0] nm_c, dm_c;
	logic [DATA_W-1:0] sra_c;

	lane_ctl_t         ctl_s [0:DIV_STAGES];
	logic [DATA_W-1:0] rem_s [0:DIV_STAGES];
	logic [DATA_W-1:0] quo_s [0:DIV_STAGES];
	logic [DATA_W-1:0] den_s [0:DIV_STAGES];

	logic [DATA_W-1:0] r_q;
	logic              zd_q;
	logic [HALF_W-1:0] cross_c;
	lane_ctl_t         fin;

	// kept apart so the shift stays signed
	assign sra_c = a >>> b[SHAMT_W-1:0];

	always_comb begin
		ctl_c      = '0;
		ctl_c.mode = MODE_SIMPLE;
		ctl_c.zd   = (b == '0);
		ctl_c.qneg = a[DATA_W-1] ^ b[DATA_W-1];
		ctl_c.rneg = a[DATA_W-1];
		nm_c       = a[DATA_W-1] ? (-a) : a;
		dm_c       = b[DATA_W-1] ? (-b) : b;
		case (op_t'(kind))
			OP_NEG: ctl_c.res = -a;
			OP_ZT:  ctl_c.res = {DATA_W{a == '0}};
			OP_NOT: ctl_c.res = ~a;
			OP_ADD: ctl_c.res = a + b;
			OP_SUB: ctl_c.res = a - b;
			OP_MUL: begin
				ctl_c.mode = MODE_MUL;
				ctl_c.res  = a[HALF_W-1:0] * b[HALF_W-1:0];
				ctl_c.p1   = HALF_W'(a[DATA_W-1:HALF_W] * b[HALF_W-1:0]);
				ctl_c.p2   = HALF_W'(a[HALF_W-1:0] * b[DATA_W-1:HALF_W]);
			end
			OP_DIV: begin
				ctl_c.mode = MODE_DIV;
				ctl_c.res  = a;
			end
			OP_MOD: begin
				ctl_c.mode = MODE_MOD;
				ctl_c.res  = a;
			end
			OP_AND: ctl_c.res = a & b;
			OP_OR:  ctl_c.res = a | b;
			OP_XOR: ctl_c.res = a ^ b;
			OP_SHL: ctl_c.res = (shl_cnt > DATA_W'(DATA_W-1)) ? '0 : (a << shl_cnt[SHAMT_W-1:0]);
			OP_SHR: ctl_c.res = (b > DATA_W'(DATA_W-1)) ? {DATA_W{a[DATA_W-1]}} : sra_c;
			OP_LT:  ctl_c.res = {DATA_W{a < b}};
			OP_GT:  ctl_c.res = {DATA_W{a > b}};
			OP_LE:  ctl_c.res = {DATA_W{a <= b}};
			OP_GE:  ctl_c.res = {DATA_W{a >= b}};
			OP_EQ:  ctl_c.res = {DATA_W{(a == b) != is_not_equal}};
			default: ctl_c.res = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s[0] <= ctl_c;
			rem_s[0] <= '0;
			quo_s[0] <= nm_c;
			den_s[0] <= dm_c;
		end
	end

	// restoring divider, one quotient bit per stage
	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
		logic [DATA_W-1:0] t;
		logic              ge;
		assign t  = {rem_s[k][DATA_W-2:0], quo_s[k][DATA_W-1]};
		assign ge = (t >= den_s[k]);
		always_ff @(posedge clk) begin
			if (en) begin
				ctl_s[k+1] <= ctl_s[k];
				rem_s[k+1] <= ge ? (t - den_s[k]) : t;
				quo_s[k+1] <= {quo_s[k][DATA_W-2:0], ge};
				den_s[k+1] <= den_s[k];
			end
		end
	end

	assign fin     = ctl_s[DIV_STAGES];
	assign cross_c = fin.p1 + fin.p2;

	always_ff @(posedge clk) begin
		if (en) begin
			case (fin.mode)
				MODE_MUL: r_q <= fin.res + {cross_c, {HALF_W{1'b0}}};
				MODE_DIV: r_q <= fin.zd ? '0
				              : (fin.qneg ? -quo_s[DIV_STAGES] : quo_s[DIV_STAGES]);
				MODE_MOD: r_q <= fin.zd ? fin.res
				              : (fin.rneg ? -rem_s[DIV_STAGES] : rem_s[DIV_STAGES]);
				default:  r_q <= fin.res;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zd_q <= 1'b0;
		end else if (en) begin
			zd_q <= fin.zd && (fin.mode == MODE_DIV || fin.mode == MODE_MOD);
		end
	end

	assign r            = r_q;
	assign zero_divisor = zd_q;

	// a nonzero divisor leaves a remainder below it
	assert property (@(posedge clk) disable iff (!arst_n)
		(den_s[DIV_STAGES] != '0) |-> (rem_s[DIV_STAGES] < den_s[DIV_STAGES]))
		else $error("divider remainder not below divisor");
	// flag only for divide and remainder beats
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(zd_q) |-> ($past(fin.mode) == MODE_DIV || $past(fin.mode) == MODE_MOD))
		else $error("zero-divisor flag on non-divide op");

endmodule

FILE: rtl/core/tlva_ctrl.sv
// Valid tracking and stall control for the lane pipeline.
// Depends on tlva_pkg for pipeline depth. Whole pipeline holds when the output beat waits.
module tlva_ctrl import tlva_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic out_ready,
	output logic in_ready,
	output logic out_valid,
	output logic en
);

	logic [PIPE_DEPTH-1:0] vld_q;

	assign en        = !vld_q[PIPE_DEPTH-1] || out_ready;
	assign in_ready  = en;
	assign out_valid = vld_q[PIPE_DEPTH-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[PIPE_DEPTH-2:0], in_valid};
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_q))
		else $error("valid chain moved during stall");
	assert property (@(posedge clk) disable iff (!arst_n)
		(en && in_valid) |=> vld_q[0])
		else $error("accepted beat not tracked");

endmodule

FILE: rtl/core/two_lane_int64_vector_alu_unit.sv
// Top level of the two-lane signed 64-bit vector ALU.
// Depends on tlva_pkg, tlva_if, tlva_lane and tlva_ctrl.
//
//   channel  dir  fields
//   req      in   kind, is_not_equal, a_x, a_y, b_x, b_y
//   rsp      out  r_x, r_y, zero_divisor_x, zero_divisor_y
//
// One beat accepted per cycle while no rsp beat waits; every op passes through the setup stage,
// the 64-stage divider and the result stage on its way from accept to rsp valid.
// Reset clears only the valid chain and flags.
// A waiting rsp beat holds the whole pipeline; req.ready drops only then.
module two_lane_int64_vector_alu_unit import tlva_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	tlva_req_if.sink    req,
	tlva_rsp_if.source  rsp
);

	logic en;

	tlva_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.out_ready (rsp.ready),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.en        (en)
	);

	tlva_lane u_lane_x (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (en),
		.kind         (req.kind),
		.is_not_equal (req.is_not_equal),
		.a            (req.a_x),
		.b            (req.b_x),
		.shl_cnt      (req.b_x),
		.r            (rsp.r_x),
		.zero_divisor (rsp.zero_divisor_x)
	);

	tlva_lane u_lane_y (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (en),
		.kind         (req.kind),
		.is_not_equal (req.is_not_equal),
		.a            (req.a_y),
		.b            (req.b_y),
		.shl_cnt      (req.b_x),
		.r            (rsp.r_y),
		.zero_divisor (rsp.zero_divisor_y)
	);

endmodule

FILE: tb/two_lane_int64_vector_alu_unit_test.sv
// Self-checking testbench for the two-lane 64-bit vector ALU: random and directed ops,
// expected lanes computed in-line and compared in order. Depends on tlva_pkg, tlva_if
// and the RTL top level two_lane_int64_vector_alu_unit.
`timescale 1ns / 100ps

module two_lane_int64_vector_alu_unit_test;
	import tlva_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES   = 2 * PIPE_DEPTH + 10;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic              ne;
		logic [63:0]       ax, ay, bx, by;
	} vec_op_t;

	typedef struct packed {
		logic [63:0] rx, ry;
		logic        zx, zy;
	} vec_res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	tlva_req_if req ();
	tlva_rsp_if rsp ();

	two_lane_int64_vector_alu_unit u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req.sink),
		.rsp    (rsp.source)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	vec_op_t  pending_ops[$];
	vec_res_t expected_lanes[$];
	int       errors = 0;
	int       src_idle_pct = 0;
	int       sink_stall_pct = 0;
	int       quiet_cycles = 0;
	bit       in_taken = 1'b0;

	localparam logic [63:0] MIN64 = 64'h8000000000000000;
	localparam logic [63:0] MAX64 = 64'h7FFFFFFFFFFFFFFF;

	function automatic logic [63:0] lane_mask(input bit t);
		return t ? '1 : '0;
	endfunction

	function automatic bit lane_slt(input logic [63:0] p, input logic [63:0] q);
		return $signed(p) < $signed(q);
	endfunction

	// truncating divide, zero divisor yields 0 / dividend
	function automatic logic [63:0] lane_divmod(input logic [63:0] n, input logic [63:0] d,
			input bit want_rem, output logic flag);
		logic [63:0] nm, dm, q;
		flag = (d == '0);
		if (flag)
			return want_rem ? n : '0;
		nm = n[63] ? -n : n;
		dm = d[63] ? -d : d;
		q = nm / dm;
		if (n[63] != d[63])
			q = -q;
		return want_rem ? n - q * d : q;
	endfunction

	function automatic logic [63:0] lane_sar(input logic [63:0] v, input logic [63:0] n);
		if (n > 63)
			return v[63] ? '1 : '0;
		return $unsigned($signed(v) >>> n[5:0]);
	endfunction

	function automatic vec_res_t alu_predict(input vec_op_t op);
		vec_res_t r;
		r = '0;
		case (op.kind)
			OP_NEG: begin r.rx = -op.ax; r.ry = -op.ay; end
			OP_ZT:  begin r.rx = lane_mask(op.ax == 0); r.ry = lane_mask(op.ay == 0); end
			OP_NOT: begin r.rx = ~op.ax; r.ry = ~op.ay; end
			OP_ADD: begin r.rx = op.ax + op.bx; r.ry = op.ay + op.by; end
			OP_SUB: begin r.rx = op.ax - op.bx; r.ry = op.ay - op.by; end
			OP_MUL: begin r.rx = op.ax * op.bx; r.ry = op.ay * op.by; end
			OP_DIV: begin
				r.rx = lane_divmod(op.ax, op.bx, 1'b0, r.zx);
				r.ry = lane_divmod(op.ay, op.by, 1'b0, r.zy);
			end
			OP_MOD: begin
				r.rx = lane_divmod(op.ax, op.bx, 1'b1, r.zx);
				r.ry = lane_divmod(op.ay, op.by, 1'b1, r.zy);
			end
			OP_AND: begin r.rx = op.ax & op.bx; r.ry = op.ay & op.by; end
			OP_OR:  begin r.rx = op.ax | op.bx; r.ry = op.ay | op.by; end
			OP_XOR: begin r.rx = op.ax ^ op.bx; r.ry = op.ay ^ op.by; end
			OP_SHL: begin
				if (op.bx <= 63) begin
					r.rx = op.ax << op.bx[5:0];
					r.ry = op.ay << op.bx[5:0];
				end
			end
			OP_SHR: begin r.rx = lane_sar(op.ax, op.bx); r.ry = lane_sar(op.ay, op.by); end
			OP_LT:  begin
				r.rx = lane_mask(lane_slt(op.ax, op.bx));
				r.ry = lane_mask(lane_slt(op.ay, op.by));
			end
			OP_GT:  begin
				r.rx = lane_mask(lane_slt(op.bx, op.ax));
				r.ry = lane_mask(lane_slt(op.by, op.ay));
			end
			OP_LE:  begin
				r.rx = lane_mask(!lane_slt(op.bx, op.ax));
				r.ry = lane_mask(!lane_slt(op.by, op.ay));
			end
			OP_GE:  begin
				r.rx = lane_mask(!lane_slt(op.ax, op.bx));
				r.ry = lane_mask(!lane_slt(op.ay, op.by));
			end
			OP_EQ:  begin
				r.rx = lane_mask((op.ax == op.bx) != op.ne);
				r.ry = lane_mask((op.ay == op.by) != op.ne);
			end
			default: r = '0;
		endcase
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		errors++;
		$display("%0t mismatch %s: got %h expected %h", $realtime, what, got, want);
	endtask

	// operand biased toward edges and small values
	function automatic logic [63:0] pick_operand();
		case ($urandom_range(0, 9))
			0: return MIN64;
			1: return MAX64;
			2: return '1;
			3: return '0;
			4: return 64'($urandom_range(0, 70));
			5: return -64'($urandom_range(1, 70));
			default: return {$urandom, $urandom};
		endcase
	endfunction

	task automatic queue_op(input logic [KIND_W-1:0] k, input logic ne,
			input logic [63:0] ax, input logic [63:0] ay,
			input logic [63:0] bx, input logic [63:0] by);
		vec_op_t op;
		op = '{kind: k, ne: ne, ax: ax, ay: ay, bx: bx, by: by};
		pending_ops.push_back(op);
	endtask

	// remember whether the req beat went at the rising edge
	always @(posedge clk) begin
		in_taken <= arst_n && req.valid && req.ready;
	end

	bit     drv_busy = 1'b0;
	vec_op_t drv_op;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quiet_cycles <= 0;
		end else begin
			if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		req.valid = 1'b0;
		req.kind = '0;
		req.is_not_equal = 1'b0;
		req.a_x = '0;
		req.a_y = '0;
		req.b_x = '0;
		req.b_y = '0;
		rsp.ready = 1'b0;
	end

	// request side: hold beat until accepted, then maybe idle
	always @(negedge clk) begin
		if (arst_n) begin
			if (drv_busy && in_taken)
				drv_busy = 1'b0;
			if (!drv_busy && pending_ops.size() > 0 &&
					$urandom_range(0, 99) >= src_idle_pct) begin
				drv_op = pending_ops.pop_front();
				drv_busy = 1'b1;
				req.kind <= drv_op.kind;
				req.is_not_equal <= drv_op.ne;
				req.a_x <= drv_op.ax;
				req.a_y <= drv_op.ay;
				req.b_x <= drv_op.bx;
				req.b_y <= drv_op.by;
			end
			req.valid <= drv_busy;
			rsp.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
		end
	end

	// predict on accepted request, check accepted response
	always @(posedge clk) begin
		vec_res_t want;
		if (arst_n) begin
			if (req.valid && req.ready)
				expected_lanes.push_back(alu_predict('{kind: req.kind, ne: req.is_not_equal,
					ax: req.a_x, ay: req.a_y, bx: req.b_x, by: req.b_y}));
			if (rsp.valid && rsp.ready) begin
				if (expected_lanes.size() == 0) begin
					report_mismatch("unexpected beat", rsp.r_x, '0);
				end else begin
					want = expected_lanes.pop_front();
					if (rsp.r_x !== want.rx) report_mismatch("r_x", rsp.r_x, want.rx);
					if (rsp.r_y !== want.ry) report_mismatch("r_y", rsp.r_y, want.ry);
					if (rsp.zero_divisor_x !== want.zx)
						report_mismatch("zero_divisor_x", 64'(rsp.zero_divisor_x), 64'(want.zx));
					if (rsp.zero_divisor_y !== want.zy)
						report_mismatch("zero_divisor_y", 64'(rsp.zero_divisor_y), 64'(want.zy));
				end
			end
		end
	end

	initial begin
		forever begin
			@(posedge clk);
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	task automatic run_phase(input int idle_pct, input int stall_pct, input int count);
		int k;
		src_idle_pct = idle_pct;
		sink_stall_pct = stall_pct;
		for (int i = 0; i < count; i++) begin
			k = $urandom_range(0, 20);
			if (k > 17 && $urandom_range(0, 3) != 0)
				k = $urandom_range(0, 17);
			else if (k > 17)
				k = $urandom_range(18, 31);
			queue_op(KIND_W'(k), 1'($urandom), pick_operand(), pick_operand(),
				pick_operand(), pick_operand());
		end
		while (pending_ops.size() > 0 || drv_busy)
			@(posedge clk);
	endtask

	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: every op, field extremes, undefined kinds
		for (int k = 0; k <= 17; k++)
			queue_op(KIND_W'(k), 1'b0, MAX64, MIN64, 64'd3, -64'd5);
		queue_op(OP_EQ, 1'b1, 64'd7, 64'd7, 64'd7, 64'd8);
		queue_op(OP_DIV, 1'b0, MIN64, 64'd9, '1, '0);
		queue_op(OP_MOD, 1'b1, MIN64, -64'd9, '1, '0);
		queue_op(OP_SHL, 1'b0, '1, 64'd1, 64'd63, '0);
		queue_op(OP_SHL, 1'b0, '1, 64'd1, 64'd64, '0);
		queue_op(OP_SHR, 1'b0, MIN64, MAX64, -64'd1, 64'd63);
		queue_op(5'd31, 1'b1, '1, '1, '1, '1);
		queue_op(5'd18, 1'b0, '0, '0, '0, '0);
		run_phase(0, 0, 0);

		run_phase(0, 0, 180);
		run_phase(71, 0, 150);
		run_phase(0, 71, 150);
		run_phase(6, 6, 170);

		while (expected_lanes.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
